[src/rrpr_pkg.sv]
// ----------------------------------------------------------------------------
// rrpr_pkg: shared types and constants for the random rank pixel reveal core
// Request and response payloads, scan states and register map.
// ----------------------------------------------------------------------------
package rrpr_pkg;

	// default number of pixel cells in the ring
	localparam int MAX_PIXELS_DEF = 64;

	// pixel_count reset value and width
	localparam int          PCOUNT_W     = 7;
	localparam logic [6:0]  PCOUNT_RESET = 7'd64;

	// register indexes (word address paddr[2])
	localparam logic REG_PIXEL_COUNT = 1'b0;

	// request payload
	typedef struct packed {
		logic       restart;
		logic [5:0] pick_rank;
	} req_t;

	// response payload
	typedef struct packed {
		logic       lit_valid;
		logic [5:0] lit_index;
		logic [6:0] dark_left;
	} rsp_t;

	// scan sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// control from the scan sequencer to the cell ring
	typedef struct packed {
		logic shift;     // rotate the ring by one cell
		logic tail_bit;  // lit mark written back into the tail cell
	} ring_ctrl_t;

endpackage

[src/random_rank_pixel_reveal_core.sv]
// ----------------------------------------------------------------------------
// random_rank_pixel_reveal_core: lights the dark pixel of a given rank
// A ring of lit-mark cells rotates past a scan sequencer, which picks the
// requested dark pixel, reports its index and the number of dark pixels left.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | restart, pick_rank
//   rsp     | out       | rsp_valid/rsp_ready  | lit_valid, lit_index, dark_left
//   cfg     | in        | APB psel/penable     | pixel_count at 0x0
//
// Each item is accepted in the idle state; the ring then makes a full turn
// past the scan head, one cell per shift.
// A new request is taken while the previous response waits in its register;
// the last scan step waits only if that register is still full.
// Reset clears all lit marks at once and sets pixel_count to 64.
// ----------------------------------------------------------------------------
module random_rank_pixel_reveal_core #(
	parameter int MAX_PIXELS = rrpr_pkg::MAX_PIXELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rrpr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rrpr_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [6:0]           pixel_count_q;
	logic [MAX_PIXELS-1:0] cell_q;
	rrpr_pkg::ring_ctrl_t ring;
	logic                 cfg_wr;

	// configuration register write
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= rrpr_pkg::PCOUNT_RESET;
		end else if (cfg_wr && (paddr[2] == rrpr_pkg::REG_PIXEL_COUNT)) begin
			pixel_count_q <= pwdata[6:0];
		end
	end

	// configuration register read
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			rrpr_pkg::REG_PIXEL_COUNT: prdata = 32'(pixel_count_q);
			default:                   prdata = '0;
		endcase
	end

	// ring of lit-mark cells; tail takes the written-back mark
	for (genvar i = 0; i < MAX_PIXELS; i++) begin : g_cell
		logic d;
		if (i == MAX_PIXELS - 1) begin : g_tail
			assign d = ring.tail_bit;
		end else begin : g_body
			assign d = cell_q[i+1];
		end
		rrpr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring.shift),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	// scan sequencer at the ring head
	rrpr_scan #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.pixel_count (pixel_count_q),
		.head_bit    (cell_q[0]),
		.ring        (ring)
	);

endmodule

[src/rrpr_cell.sv]
// ----------------------------------------------------------------------------
// rrpr_cell: one pixel cell of the lit-mark ring
// Holds one lit mark and loads its neighbor's mark on every shift.
// ----------------------------------------------------------------------------
module rrpr_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic d,
	output logic q
);

	logic lit_q;

	// lit mark, moves one cell toward the head per shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= 1'b0;
		end else if (shift) begin
			lit_q <= d;
		end
	end

	assign q = lit_q;

endmodule

[src/rrpr_scan.sv]
// ----------------------------------------------------------------------------
// rrpr_scan: scan sequencer at the head of the cell ring
// Looks at one pixel per cycle as the ring turns, the last one waiting for a
// free response register; picks the dark pixel of the requested rank, writes
// the updated mark to the tail and holds the response in an output register.
// ----------------------------------------------------------------------------
module rrpr_scan #(
	parameter int MAX_PIXELS = rrpr_pkg::MAX_PIXELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rrpr_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rrpr_pkg::rsp_t       rsp,
	input  logic [6:0]           pixel_count,
	input  logic                 head_bit,
	output rrpr_pkg::ring_ctrl_t ring
);

	localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = PW + rrpr_pkg::PCOUNT_W;

	rrpr_pkg::state_t state_q, state_d;
	logic [PW-1:0]    p_q;
	logic             restart_q;
	logic [5:0]       rem_q;
	logic             found_q;
	logic [5:0]       hit_q;
	logic [6:0]       dark_q;
	rrpr_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic             req_xfer;
	logic             last;
	logic             slot_free;
	logic             advance;
	logic             eff_bit;
	logic             in_use;
	logic             dark_px;
	logic             take;
	logic [PW+5:0]    p_ext;
	logic             found_n;
	logic [5:0]       hit_n;
	logic [6:0]       dark_n;

	// per-pixel decision at the ring head
	always_comb begin
		req_xfer  = req_valid && req_ready;
		last      = (p_q == PW'(MAX_PIXELS - 1));
		slot_free = !rsp_valid_q || rsp_ready;
		eff_bit   = restart_q ? 1'b0 : head_bit;
		in_use    = (CW'(p_q) < CW'(pixel_count));
		dark_px   = in_use && !eff_bit;
		take      = dark_px && !found_q && (rem_q == 6'd0);
		p_ext     = (PW + 6)'(p_q);
		found_n   = found_q || take;
		hit_n     = take ? p_ext[5:0] : hit_q;
		dark_n    = dark_q + 7'((dark_px && !take) ? 1 : 0);
	end

	// sequencer next state and ring control
	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		advance       = 1'b0;
		unique case (state_q)
			rrpr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = rrpr_pkg::ST_SCAN;
				end
			end
			rrpr_pkg::ST_SCAN: begin
				advance = !last || slot_free;
				if (last && slot_free) begin
					state_d = rrpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rrpr_pkg::ST_IDLE;
			end
		endcase
		ring.shift    = advance;
		ring.tail_bit = eff_bit || take;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q       <= '0;
			restart_q <= 1'b0;
			rem_q     <= '0;
			found_q   <= 1'b0;
			hit_q     <= '0;
			dark_q    <= '0;
		end else if (req_xfer) begin
			p_q       <= '0;
			restart_q <= req.restart;
			rem_q     <= req.pick_rank;
			found_q   <= 1'b0;
			hit_q     <= '0;
			dark_q    <= '0;
		end else if (advance) begin
			p_q     <= p_q + PW'(1);
			found_q <= found_n;
			hit_q   <= hit_n;
			dark_q  <= dark_n;
			if (dark_px && (rem_q != 6'd0)) begin
				rem_q <= rem_q - 6'd1;
			end
		end
	end

	// response register, loaded on the last pixel of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last) begin
			rsp_q.lit_valid <= found_n;
			rsp_q.lit_index <= found_n ? hit_n : 6'd0;
			rsp_q.dark_left <= dark_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// an accepted request starts a scan at pixel zero
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> (state_q == rrpr_pkg::ST_SCAN) && (p_q == '0))
		else $error("scan did not start at pixel zero");

	// once a pixel is picked it stays picked until the next request
	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !req_xfer) |=> found_q)
		else $error("pick lost during scan");

	// a response appears only at the end of a scan
	a_rsp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == rrpr_pkg::ST_SCAN))
		else $error("response without a scan");

	// the ring never rotates while idle
	a_no_idle_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrpr_pkg::ST_IDLE) |-> !ring.shift)
		else $error("ring shifted while idle");
`endif

endmodule
